FILE: hw/rtl/x86dec_pkg.sv
// ----------------------------------------------------------------------------
// x86dec_pkg: shared types and decode helpers for the 8086 byte decoder
// Item structs for both channels, operation and form codes, opcode
// classification and instruction layout functions.
// ----------------------------------------------------------------------------
package x86dec_pkg;

    // Input transaction: one code byte of the instruction stream
    typedef struct packed {
        logic [7:0] code_byte;
        logic       stream_end;
    } t_in_item;

    // Output transaction: one decoded instruction record
    typedef struct packed {
        logic [2:0]         operation;
        logic [2:0]         form;
        logic [3:0]         condition;
        logic               reg_is_dest;
        logic               is_word;
        logic [1:0]         mod_field;
        logic [2:0]         reg_field;
        logic [2:0]         rm_field;
        logic signed [15:0] displacement;
        logic [15:0]        immediate;
        logic [2:0]         length;
        logic               truncated;
    } t_out_item;

    // Operation codes
    localparam logic [2:0] OP_MOV   = 3'd0;
    localparam logic [2:0] OP_ADD   = 3'd1;
    localparam logic [2:0] OP_SUB   = 3'd2;
    localparam logic [2:0] OP_CMP   = 3'd3;
    localparam logic [2:0] OP_JCC   = 3'd4;
    localparam logic [2:0] OP_OTHER = 3'd5;

    // Instruction form codes
    localparam logic [2:0] FORM_RM_REG     = 3'd0;
    localparam logic [2:0] FORM_IMM_RM     = 3'd1;
    localparam logic [2:0] FORM_IMM_REG    = 3'd2;
    localparam logic [2:0] FORM_IMM_ACC    = 3'd3;
    localparam logic [2:0] FORM_MEM_ACC    = 3'd4;
    localparam logic [2:0] FORM_ACC_MEM    = 3'd5;
    localparam logic [2:0] FORM_JUMP       = 3'd6;

    // Opcode patterns
    localparam logic [7:0] OPC_JCC_SKIP    = 8'h79;
    localparam logic [3:0] OPC_JCC_HI      = 4'h7;
    localparam logic [6:0] OPC7_MEM_ACC    = 7'h50;
    localparam logic [6:0] OPC7_ACC_MEM    = 7'h51;
    localparam logic [6:0] OPC7_MOV_IMM_RM = 7'h63;
    localparam logic [6:0] OPC7_ADD_ACC    = 7'h02;
    localparam logic [6:0] OPC7_SUB_ACC    = 7'h16;
    localparam logic [6:0] OPC7_CMP_ACC    = 7'h1E;
    localparam logic [5:0] OPC6_MOV_RM     = 6'h22;
    localparam logic [5:0] OPC6_ADD_RM     = 6'h00;
    localparam logic [5:0] OPC6_SUB_RM     = 6'h0A;
    localparam logic [5:0] OPC6_CMP_RM     = 6'h0E;
    localparam logic [5:0] OPC6_GROUP      = 6'h20;
    localparam logic [3:0] OPC_MOV_IMM_REG = 4'hB;

    // Group / accumulator sub-op selectors
    localparam logic [2:0] GRP_ADD = 3'd0;
    localparam logic [2:0] GRP_SUB = 3'd5;
    localparam logic [2:0] GRP_CMP = 3'd7;

    // Special mod/rm codes
    localparam logic [1:0] MOD_NO_DISP  = 2'd0;
    localparam logic [1:0] MOD_DISP8    = 2'd1;
    localparam logic [1:0] MOD_DISP16   = 2'd2;
    localparam logic [2:0] RM_DIRECT    = 3'd6;

    typedef enum logic [3:0] {
        K_NONE,
        K_JCC,
        K_MEMACC,
        K_ACCMEM,
        K_MOVIRM,
        K_IMMACC,
        K_RMREG,
        K_GRP,
        K_MOVIREG
    } t_kind;

    typedef struct packed {
        logic       has_mrm;
        logic [1:0] disp_len;
        logic [1:0] imm_len;
    } t_layout;

    function automatic t_kind classify(input logic [7:0] op);
        logic [6:0] op7;
        logic [5:0] op6;
        t_kind      kind;
        op7 = op[7:1];
        op6 = op[7:2];
        if (op[7:4] == OPC_JCC_HI && op != OPC_JCC_SKIP) begin
            kind = K_JCC;
        end else if (op7 == OPC7_MEM_ACC) begin
            kind = K_MEMACC;
        end else if (op7 == OPC7_ACC_MEM) begin
            kind = K_ACCMEM;
        end else if (op7 == OPC7_MOV_IMM_RM) begin
            kind = K_MOVIRM;
        end else if (op7 == OPC7_ADD_ACC || op7 == OPC7_SUB_ACC || op7 == OPC7_CMP_ACC) begin
            kind = K_IMMACC;
        end else if (op6 == OPC6_MOV_RM || op6 == OPC6_ADD_RM || op6 == OPC6_SUB_RM
                     || op6 == OPC6_CMP_RM) begin
            kind = K_RMREG;
        end else if (op6 == OPC6_GROUP) begin
            kind = K_GRP;
        end else if (op[7:4] == OPC_MOV_IMM_REG) begin
            kind = K_MOVIREG;
        end else begin
            kind = K_NONE;
        end
        return kind;
    endfunction

    function automatic logic [1:0] modrm_disp_len(input logic [7:0] mrm);
        logic [1:0] len;
        case (mrm[7:6])
            MOD_NO_DISP: len = (mrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
            MOD_DISP8:   len = 2'd1;
            MOD_DISP16:  len = 2'd2;
            default:     len = 2'd0;
        endcase
        return len;
    endfunction

    function automatic t_layout layout(input t_kind kind, input logic [7:0] op,
                                       input logic [7:0] mrm);
        t_layout lay;
        lay = '0;
        case (kind)
            K_JCC:    lay.disp_len = 2'd1;
            K_MEMACC: lay.disp_len = 2'd2;
            K_ACCMEM: lay.disp_len = 2'd2;
            K_IMMACC: lay.imm_len = op[0] ? 2'd2 : 2'd1;
            K_MOVIREG: lay.imm_len = op[3] ? 2'd2 : 2'd1;
            K_RMREG: begin
                lay.has_mrm  = 1'b1;
                lay.disp_len = modrm_disp_len(mrm);
            end
            K_MOVIRM: begin
                lay.has_mrm  = 1'b1;
                lay.disp_len = modrm_disp_len(mrm);
                lay.imm_len  = op[0] ? 2'd2 : 2'd1;
            end
            K_GRP: begin
                lay.has_mrm  = 1'b1;
                lay.disp_len = modrm_disp_len(mrm);
                lay.imm_len  = (op[0] && !op[1]) ? 2'd2 : 2'd1;
            end
            default: lay = '0;
        endcase
        return lay;
    endfunction

endpackage

FILE: hw/rtl/x86dec_step.sv
// ----------------------------------------------------------------------------
// x86dec_step: instruction position tracker and record builder
// Holds the partial instruction, folds in one byte per advance and builds
// the decoded record when the instruction completes or the stream ends.
// ----------------------------------------------------------------------------
module x86dec_step (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,
    input  x86dec_pkg::t_in_item   i_item,
    output logic                   o_emit,
    output x86dec_pkg::t_out_item  o_record
);
    import x86dec_pkg::*;

    logic [2:0]  r_pos, n_pos;
    logic [2:0]  r_exp, n_exp;
    logic [7:0]  r_opcode, n_opcode;
    logic [7:0]  r_mrm, n_mrm;
    logic [15:0] r_disp, n_disp;
    logic [15:0] r_imm, n_imm;

    t_kind       cur_kind;
    t_layout     cur_lay;
    t_layout     mrm_lay;
    logic [2:0]  off;
    logic [2:0]  imm_off;
    logic        active;
    logic        done;

    // Next state for one byte
    always_comb begin
        n_pos    = r_pos;
        n_exp    = r_exp;
        n_opcode = r_opcode;
        n_mrm    = r_mrm;
        n_disp   = r_disp;
        n_imm    = r_imm;
        active   = 1'b0;
        cur_kind = classify((r_pos == 3'd0) ? i_item.code_byte : r_opcode);
        cur_lay  = layout(cur_kind, (r_pos == 3'd0) ? i_item.code_byte : r_opcode,
                          (r_pos == 3'd0) ? 8'h00 : r_mrm);
        mrm_lay  = layout(cur_kind, r_opcode, i_item.code_byte);
        off      = r_pos - 3'd1 - {2'b00, cur_lay.has_mrm};
        imm_off  = off - {1'b0, cur_lay.disp_len};

        if (r_pos == 3'd0) begin
            if (cur_kind != K_NONE) begin
                active   = 1'b1;
                n_opcode = i_item.code_byte;
                n_mrm    = 8'h00;
                n_disp   = 16'h0000;
                n_imm    = 16'h0000;
                n_exp    = cur_lay.has_mrm ? 3'd0
                         : 3'd1 + {1'b0, cur_lay.disp_len} + {1'b0, cur_lay.imm_len};
                n_pos    = 3'd1;
            end
        end else begin
            active = 1'b1;
            if (cur_lay.has_mrm && r_pos == 3'd1) begin
                n_mrm = i_item.code_byte;
                n_exp = 3'd2 + {1'b0, mrm_lay.disp_len} + {1'b0, mrm_lay.imm_len};
            end else if (off < {1'b0, cur_lay.disp_len}) begin
                if (off[0]) n_disp[15:8] = r_disp[15:8] | i_item.code_byte;
                else        n_disp[7:0]  = r_disp[7:0]  | i_item.code_byte;
            end else begin
                if (imm_off[0]) n_imm[15:8] = r_imm[15:8] | i_item.code_byte;
                else            n_imm[7:0]  = r_imm[7:0]  | i_item.code_byte;
            end
            n_pos = r_pos + 3'd1;
        end

        done   = (n_exp != 3'd0) && (n_pos >= n_exp);
        o_emit = active && (done || i_item.stream_end);
    end

    // Build the record from the updated instruction state
    always_comb begin
        t_kind   rk;
        t_layout rl;
        logic [2:0] grp;
        rk  = classify(n_opcode);
        rl  = layout(rk, n_opcode, n_mrm);
        grp = 3'd0;

        o_record              = '0;
        o_record.is_word      = n_opcode[0];
        o_record.displacement = (rl.disp_len == 2'd1) ? {{8{n_disp[7]}}, n_disp[7:0]} : n_disp;
        o_record.immediate    = n_imm;
        o_record.length       = n_pos;
        o_record.truncated    = !done;
        if (rl.has_mrm) begin
            o_record.mod_field = n_mrm[7:6];
            o_record.reg_field = n_mrm[5:3];
            o_record.rm_field  = n_mrm[2:0];
        end

        case (rk)
            K_JCC: begin
                o_record.operation = OP_JCC;
                o_record.form      = FORM_JUMP;
                o_record.condition = n_opcode[3:0];
                o_record.is_word   = 1'b0;
            end
            K_MEMACC: o_record.form = FORM_MEM_ACC;
            K_ACCMEM: o_record.form = FORM_ACC_MEM;
            K_MOVIRM: o_record.form = FORM_IMM_RM;
            K_MOVIREG: begin
                o_record.form      = FORM_IMM_REG;
                o_record.is_word   = n_opcode[3];
                o_record.reg_field = n_opcode[2:0];
            end
            K_IMMACC: begin
                o_record.form = FORM_IMM_ACC;
                grp = n_opcode[5:3];
                o_record.operation = (grp == GRP_ADD) ? OP_ADD
                                   : (grp == GRP_SUB) ? OP_SUB : OP_CMP;
            end
            K_RMREG: begin
                o_record.form        = FORM_RM_REG;
                o_record.reg_is_dest = n_opcode[1];
                o_record.operation   = (n_opcode[7:2] == OPC6_MOV_RM) ? OP_MOV
                                     : (n_opcode[7:2] == OPC6_ADD_RM) ? OP_ADD
                                     : (n_opcode[7:2] == OPC6_SUB_RM) ? OP_SUB : OP_CMP;
            end
            K_GRP: begin
                o_record.form = FORM_IMM_RM;
                grp = n_mrm[5:3];
                o_record.operation = (grp == GRP_ADD) ? OP_ADD
                                   : (grp == GRP_SUB) ? OP_SUB
                                   : (grp == GRP_CMP) ? OP_CMP : OP_OTHER;
                // sign-extend a byte immediate when s and w are both set
                if (n_opcode[1:0] == 2'b11 && n_imm[7]) begin
                    o_record.immediate = {8'hFF, n_imm[7:0]};
                end
            end
            default: o_record.operation = OP_MOV;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= 3'd0;
            r_exp <= 3'd0;
        end else if (i_advance) begin
            r_pos <= o_emit ? 3'd0 : n_pos;
            r_exp <= o_emit ? 3'd0 : n_exp;
        end
    end

    // payload registers need no reset: they are cleared at each opcode
    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_opcode <= n_opcode;
            r_mrm    <= n_mrm;
            r_disp   <= n_disp;
            r_imm    <= n_imm;
        end
    end

endmodule

FILE: hw/rtl/x86_16_instruction_byte_decoder.sv
// ----------------------------------------------------------------------------
// x86_16_instruction_byte_decoder: 8086 instruction byte stream decoder
// Takes one code byte per transaction, tracks its place in the instruction
// and delivers one decoded record when the instruction's last byte arrives or a stream end cuts it short.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_item) carries one code byte
//   and a stream_end flag per transaction. Output channel (o_out_valid /
//   i_out_ready / o_out_item) carries one decoded record per instruction.
//   Bytes that do not start a supported instruction produce no record.
//   A stream_end on a byte in mid-instruction flushes a truncated record.
// Path: the transaction carrying the instruction's last byte is accepted into
//   the input register, and the decode pass then loads the record into the
//   output register once that register is free.
// Throughput: one byte per cycle while the receiver takes records; the
//   decode pass is a single registered step whose loops are the 3-bit byte
//   position, the expected length and the gathered bytes, each fed back.
// Reset: synchronous, active low; clears both valid flags and the position
//   tracker, so the first accepted byte is treated as an opcode.
// Stall: while a record waits in the output register, the decode pass holds;
//   one more byte is still taken into the input register, then o_in_ready
//   drops until the record is taken.
// ----------------------------------------------------------------------------
module x86_16_instruction_byte_decoder (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  x86dec_pkg::t_in_item   i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output x86dec_pkg::t_out_item  o_out_item
);
    import x86dec_pkg::*;

    logic       r_in_valid;
    t_in_item   r_in_item;
    logic       r_out_valid;
    t_out_item  r_out_item;

    logic       advance;
    logic       emit;
    t_out_item  record;

    // Move the held byte through decode once the output slot is free
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    x86dec_step u_step (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_emit    (emit),
        .o_record  (record)
    );

    // Input register: hold the byte until decode takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // Output register: load a record, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && emit) begin
            r_out_item <= record;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A delivered record always covers one to six bytes
    a_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.length != 3'd0 && o_out_item.length != 3'd7))
        else $error("record length out of range");

    // A complete conditional jump is exactly opcode plus one offset byte
    a_jump_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.truncated && o_out_item.form == FORM_JUMP)
        |-> o_out_item.length == 3'd2)
        else $error("complete jump record with wrong length");

    // Jump form and jump operation always travel together
    a_jump_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.form == FORM_JUMP)
        |-> (o_out_item.operation == OP_JCC && !o_out_item.is_word))
        else $error("jump form with inconsistent operation");

    // A held byte waits while the output register is blocked
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_item)))
        else $error("input register lost a byte under stall");

    // Nothing is presented right after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 8086 instruction byte decoder
// Feeds code bytes over the input channel, runs a bit-accurate decoder of its
// own on each accepted byte, and compares every record that leaves the block
// field by field with the oldest one still pending. Directed instructions
// come first, then random well-formed instructions mixed with noise and cut
// streams, under three idle patterns on the two channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import x86dec_pkg::*;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int ITEMS_PER_PASS = 317;
    localparam int DRAIN_CYCLES   = 8;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in_item   = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out_item;

    // Decoder state mirrored by the bench: position inside the instruction,
    // full length once known (0 while unknown), and the bytes gathered so far
    int          dec_pos;
    int          dec_len;
    logic [7:0]  dec_opc;
    logic [7:0]  dec_mrm;
    logic [15:0] dec_disp;
    logic [15:0] dec_imm;

    t_out_item pending_records[$];
    t_out_item oldest_record;
    int        mismatch_count    = 0;
    int        items_sent        = 0;
    int        cycle_count       = 0;
    int        sender_idle_pct   = 0;
    int        receiver_idle_pct = 0;

    x86_16_instruction_byte_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Instruction decoding
    // ------------------------------------------------------------------

    // Sort an opcode into its instruction family; the families do not
    // overlap, so the order of the tests does not matter
    function automatic t_kind opcode_kind(input logic [7:0] op);
        if (op[7:4] == OPC_JCC_HI) begin
            return (op == OPC_JCC_SKIP) ? K_NONE : K_JCC;
        end
        if (op[7:4] == OPC_MOV_IMM_REG) begin
            return K_MOVIREG;
        end
        if (op[7:2] == OPC6_GROUP) begin
            return K_GRP;
        end
        if (op[7:2] == OPC6_MOV_RM || op[7:2] == OPC6_ADD_RM
            || op[7:2] == OPC6_SUB_RM || op[7:2] == OPC6_CMP_RM) begin
            return K_RMREG;
        end
        if (op[7:1] == OPC7_ADD_ACC || op[7:1] == OPC7_SUB_ACC
            || op[7:1] == OPC7_CMP_ACC) begin
            return K_IMMACC;
        end
        if (op[7:1] == OPC7_MOV_IMM_RM) begin
            return K_MOVIRM;
        end
        if (op[7:1] == OPC7_MEM_ACC) begin
            return K_MEMACC;
        end
        if (op[7:1] == OPC7_ACC_MEM) begin
            return K_ACCMEM;
        end
        return K_NONE;
    endfunction

    // Displacement bytes that an addressing byte calls for
    function automatic int addressing_disp_bytes(input logic [7:0] m);
        case (m[7:6])
            MOD_NO_DISP: return (m[2:0] == RM_DIRECT) ? 2 : 0;
            MOD_DISP8:   return 1;
            MOD_DISP16:  return 2;
            default:     return 0;
        endcase
    endfunction

    // Shape of an instruction: addressing byte present, displacement and
    // immediate byte counts
    function automatic void instruction_shape(input t_kind k, input logic [7:0] op,
                                              input logic [7:0] m, output bit has_mrm,
                                              output int disp_n, output int imm_n);
        has_mrm = 1'b0;
        disp_n  = 0;
        imm_n   = 0;
        case (k)
            K_JCC:              disp_n = 1;
            K_MEMACC, K_ACCMEM: disp_n = 2;
            K_IMMACC:           imm_n = op[0] ? 2 : 1;
            K_MOVIREG:          imm_n = op[3] ? 2 : 1;
            K_RMREG: begin
                has_mrm = 1'b1;
                disp_n  = addressing_disp_bytes(m);
            end
            K_MOVIRM: begin
                has_mrm = 1'b1;
                disp_n  = addressing_disp_bytes(m);
                imm_n   = op[0] ? 2 : 1;
            end
            K_GRP: begin
                has_mrm = 1'b1;
                disp_n  = addressing_disp_bytes(m);
                // s=1 takes a byte immediate even for word operations
                imm_n   = (op[0] && !op[1]) ? 2 : 1;
            end
            default: ;
        endcase
    endfunction

    // Build the record for the instruction gathered so far
    function automatic t_out_item decoded_record(input bit cut_short);
        t_out_item   rec;
        t_kind       k;
        bit          has_mrm;
        int          disp_n;
        int          imm_n;
        logic [2:0]  sub_op;
        logic [15:0] imm;
        k = opcode_kind(dec_opc);
        instruction_shape(k, dec_opc, dec_mrm, has_mrm, disp_n, imm_n);
        rec = '0;
        imm = dec_imm;
        rec.displacement = (disp_n == 1) ? {{8{dec_disp[7]}}, dec_disp[7:0]} : dec_disp;
        if (has_mrm) begin
            rec.mod_field = dec_mrm[7:6];
            rec.reg_field = dec_mrm[5:3];
            rec.rm_field  = dec_mrm[2:0];
        end
        rec.is_word = dec_opc[0];
        case (k)
            K_JCC: begin
                rec.operation = OP_JCC;
                rec.form      = FORM_JUMP;
                rec.condition = dec_opc[3:0];
                rec.is_word   = 1'b0;
            end
            K_MEMACC: begin
                rec.operation = OP_MOV;
                rec.form      = FORM_MEM_ACC;
            end
            K_ACCMEM: begin
                rec.operation = OP_MOV;
                rec.form      = FORM_ACC_MEM;
            end
            K_MOVIRM: begin
                rec.operation = OP_MOV;
                rec.form      = FORM_IMM_RM;
            end
            K_MOVIREG: begin
                rec.operation = OP_MOV;
                rec.form      = FORM_IMM_REG;
                rec.is_word   = dec_opc[3];
                rec.reg_field = dec_opc[2:0];
            end
            K_IMMACC: begin
                rec.form = FORM_IMM_ACC;
                sub_op   = dec_opc[5:3];
                rec.operation = (sub_op == GRP_ADD) ? OP_ADD :
                                (sub_op == GRP_SUB) ? OP_SUB : OP_CMP;
            end
            K_RMREG: begin
                rec.form        = FORM_RM_REG;
                rec.reg_is_dest = dec_opc[1];
                rec.operation = (dec_opc[7:2] == OPC6_MOV_RM) ? OP_MOV :
                                (dec_opc[7:2] == OPC6_ADD_RM) ? OP_ADD :
                                (dec_opc[7:2] == OPC6_SUB_RM) ? OP_SUB : OP_CMP;
            end
            K_GRP: begin
                rec.form = FORM_IMM_RM;
                sub_op   = dec_mrm[5:3];
                rec.operation = (sub_op == GRP_ADD) ? OP_ADD :
                                (sub_op == GRP_SUB) ? OP_SUB :
                                (sub_op == GRP_CMP) ? OP_CMP : OP_OTHER;
                // Sign-extend the byte immediate when both s and w are set
                if (dec_opc[1:0] == 2'b11 && imm[7]) begin
                    imm = {8'hFF, imm[7:0]};
                end
            end
            default: ;
        endcase
        rec.immediate = imm;
        rec.length    = dec_pos[2:0];
        rec.truncated = cut_short;
        return rec;
    endfunction

    // Advance the decoder by one accepted byte; queue a record when the
    // instruction completes or the stream ends inside it
    task automatic decode_byte(input logic [7:0] b, input logic last_in_stream);
        t_kind k;
        bit    has_mrm;
        int    disp_n;
        int    imm_n;
        int    slot;
        if (dec_pos == 0) begin
            k = opcode_kind(b);
            // Unknown opcodes vanish, stream end or not
            if (k == K_NONE) begin
                return;
            end
            dec_opc  = b;
            dec_mrm  = '0;
            dec_disp = '0;
            dec_imm  = '0;
            instruction_shape(k, b, 8'h00, has_mrm, disp_n, imm_n);
            dec_len = has_mrm ? 0 : 1 + disp_n + imm_n;
            dec_pos = 1;
        end else begin
            k = opcode_kind(dec_opc);
            instruction_shape(k, dec_opc, dec_mrm, has_mrm, disp_n, imm_n);
            if (has_mrm && dec_pos == 1) begin
                dec_mrm = b;
                instruction_shape(k, dec_opc, b, has_mrm, disp_n, imm_n);
                dec_len = 2 + disp_n + imm_n;
            end else begin
                slot = dec_pos - 1 - int'(has_mrm);
                if (slot < disp_n) begin
                    dec_disp = dec_disp | (16'(b) << (8 * (slot % 2)));
                end else begin
                    dec_imm = dec_imm | (16'(b) << (8 * ((slot - disp_n) % 2)));
                end
            end
            dec_pos = (dec_pos + 1) % 8;
        end
        if (dec_len != 0 && dec_pos >= dec_len) begin
            pending_records.push_back(decoded_record(1'b0));
            dec_pos = 0;
            dec_len = 0;
        end else if (last_in_stream) begin
            pending_records.push_back(decoded_record(1'b1));
            dec_pos = 0;
            dec_len = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // Input channel
    // ------------------------------------------------------------------

    // Present one byte, hold it until the block takes it, then decode it.
    // Entered and left at a rising edge; valid stays high between
    // back-to-back transactions.
    task automatic send_byte(input logic [7:0] b, input logic last_in_stream);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= '{code_byte: b, stream_end: last_in_stream};
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        decode_byte(b, last_in_stream);
    endtask

    // ------------------------------------------------------------------
    // Output channel and checking
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch %0d at cycle %0d: %s got %0d expected %0d",
                 mismatch_count, cycle_count, what, got, want);
    endtask

    task automatic compare_record(input t_out_item got, input t_out_item want);
        if (got.operation !== want.operation)
            report_mismatch("operation", got.operation, want.operation);
        if (got.form !== want.form)
            report_mismatch("form", got.form, want.form);
        if (got.condition !== want.condition)
            report_mismatch("condition", got.condition, want.condition);
        if (got.reg_is_dest !== want.reg_is_dest)
            report_mismatch("reg_is_dest", got.reg_is_dest, want.reg_is_dest);
        if (got.is_word !== want.is_word)
            report_mismatch("is_word", got.is_word, want.is_word);
        if (got.mod_field !== want.mod_field)
            report_mismatch("mod_field", got.mod_field, want.mod_field);
        if (got.reg_field !== want.reg_field)
            report_mismatch("reg_field", got.reg_field, want.reg_field);
        if (got.rm_field !== want.rm_field)
            report_mismatch("rm_field", got.rm_field, want.rm_field);
        if (got.displacement !== want.displacement)
            report_mismatch("displacement", got.displacement, want.displacement);
        if (got.immediate !== want.immediate)
            report_mismatch("immediate", got.immediate, want.immediate);
        if (got.length !== want.length)
            report_mismatch("length", got.length, want.length);
        if (got.truncated !== want.truncated)
            report_mismatch("truncated", got.truncated, want.truncated);
    endtask

    // Match each record taken from the block against the oldest pending one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (pending_records.size() == 0) begin
                report_mismatch("record with nothing pending, length", o_out_item.length, 0);
            end else begin
                oldest_record = pending_records.pop_front();
                compare_record(o_out_item, oldest_record);
            end
        end
    end

    // Watchdog: end the run if the block stops making progress
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_reset();
        dec_pos  = 0;
        dec_len  = 0;
        dec_opc  = '0;
        dec_mrm  = '0;
        dec_disp = '0;
        dec_imm  = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
    endtask

    // Jump with condition 15 and a negative offset; the hole at 0x79 must
    // vanish even with the stream end set on it
    task automatic test_jumps();
        send_byte(8'h7F, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(OPC_JCC_SKIP, 1'b1);
    endtask

    // ADD with a negative 8-bit displacement, then a register-to-register MOV
    task automatic test_register_forms();
        send_byte(8'h03, 1'b0);
        send_byte(8'h46, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h89, 1'b0);
        send_byte(8'hD8, 1'b0);
    endtask

    // Group CMP on a direct address with a sign-extended byte immediate,
    // a group op outside ADD/SUB/CMP, MOV immediate in register mode
    // (no displacement), and SUB on the accumulator with a word immediate
    task automatic test_immediate_forms();
        send_byte(8'h83, 1'b0);
        send_byte(8'h3E, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h12, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hC6, 1'b0);
        send_byte(8'hC0, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h2D, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
    endtask

    // Cut a group op off in its displacement, then feed an unknown byte
    task automatic test_truncation();
        send_byte(8'h81, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h34, 1'b1);
        send_byte(8'h0F, 1'b0);
    endtask

    // One instruction with random content: mostly a known opcode, sometimes
    // a group op or MOV immediate to widen the long forms, sometimes noise;
    // any byte may carry a stream end and cut the instruction short
    task automatic send_random_instruction();
        logic [7:0] op;
        int         pick;
        pick = $urandom_range(99);
        if (pick < 10) begin
            op = 8'($urandom_range(255));
        end else if (pick < 25) begin
            op = $urandom_range(1) ? {OPC6_GROUP, 2'($urandom_range(3))}
                                   : {OPC7_MOV_IMM_RM, 1'($urandom_range(1))};
        end else begin
            do op = 8'($urandom_range(255)); while (opcode_kind(op) == K_NONE);
        end
        send_byte(op, $urandom_range(99) < 3);
        while (dec_pos != 0) begin
            send_byte(8'($urandom_range(255)), $urandom_range(99) < 4);
        end
    endtask

    task automatic test_random_stream(input int send_idle, input int take_idle);
        int target;
        sender_idle_pct   = send_idle;
        receiver_idle_pct = take_idle;
        target = items_sent + ITEMS_PER_PASS;
        while (items_sent < target) begin
            send_random_instruction();
        end
    endtask

    initial begin
        sender_idle_pct   = 19;
        receiver_idle_pct = 56;
        test_reset();
        test_jumps();
        test_register_forms();
        test_immediate_forms();
        test_truncation();
        test_random_stream(19, 56);
        test_random_stream(56, 19);
        test_random_stream(0, 0);
        i_in_valid <= 1'b0;

        // Drain: wait for every pending record, then wait DRAIN_CYCLES longer to
        // catch anything extra the block might still deliver
        while (pending_records.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_records.size() != 0) begin
            report_mismatch("records never delivered", 0, pending_records.size());
        end

        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
